// File: rtl/core/insertion_sorter_macros.svh
// assertion macros used by the rtl datapath
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ISORT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ISORT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ISORT_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define ISORT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/isort_pkg.sv
package isort_pkg;

  localparam int DEPTH     = 32;
  localparam int KEY_WIDTH = 32;
  localparam int FIELD_W   = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef struct packed {
    logic drop;
    logic load;
    logic shift;
    logic put;
    logic emit_rd;
    logic out_load;
    logic advance;
    logic clear;
  } isort_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic precede;
    logic y_one;
    logic final_item;
    logic out_fire;
    logic run_end;
  } isort_stat_t;

endpackage

// File: rtl/core/isort_if.sv
interface isort_in_if;
  logic                        valid;
  logic                        ready;
  logic [isort_pkg::FIELD_W-1:0] key;
  logic                        final_item;

  modport source (output valid, output key, output final_item, input ready);
  modport sink (input valid, input key, input final_item, output ready);
endinterface

interface isort_out_if;
  logic                        valid;
  logic                        ready;
  logic [isort_pkg::FIELD_W-1:0] sorted_key;
  logic                        run_end;
  logic                        overflow;

  modport source (output valid, output sorted_key, output run_end, output overflow,
                  input ready);
  modport sink (input valid, input sorted_key, input run_end, input overflow,
                output ready);
endinterface

interface isort_cfg_if;
  logic valid;
  logic ready;
  logic descending;

  modport source (output valid, output descending, input ready);
  modport sink (input valid, input descending, output ready);
endinterface

// File: rtl/core/isort_ctrl.sv
module isort_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_final_item,
  output logic                   in_ready,
  input  isort_pkg::isort_stat_t stat,
  output isort_pkg::isort_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_PUT  = 7'b0001000,
    S_ERD  = 7'b0010000,
    S_ELD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.full) begin
            cmd.drop  = 1'b1;
            state_nxt = in_final_item ? S_ERD : S_IDLE;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = stat.empty ? S_PUT : S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.precede) begin
          cmd.shift = 1'b1;
          state_nxt = stat.y_one ? S_PUT : S_SCAN;
        end else begin
          cmd.put   = 1'b1;
          state_nxt = stat.final_item ? S_ERD : S_IDLE;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = stat.final_item ? S_ERD : S_IDLE;
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_ELD;
      end
      S_ELD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (stat.out_fire) begin
          if (stat.run_end) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/isort_dp.sv
`include "insertion_sorter_macros.svh"

module isort_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [isort_pkg::FIELD_W-1:0]  in_key,
  input  logic                           in_final_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_descending,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [isort_pkg::FIELD_W-1:0]  out_sorted_key,
  output logic                           out_run_end,
  output logic                           out_overflow,
  input  isort_pkg::isort_cmd_t          cmd,
  output isort_pkg::isort_stat_t         stat
);

  localparam int ADDR_W = isort_pkg::ADDR_W;
  localparam int CNT_W  = isort_pkg::CNT_W;
  localparam int KW     = isort_pkg::KEY_WIDTH;

  logic [KW-1:0]     mem [isort_pkg::DEPTH];
  logic [KW-1:0]     rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [KW-1:0]     wr_data;

  logic [KW-1:0]     key_r;
  logic              final_r;
  logic              desc_r;
  logic [CNT_W-1:0]  count_r;
  logic              dropped_r;
  logic [ADDR_W-1:0] y_r;
  logic [ADDR_W-1:0] idx_r;

  logic              out_valid_r;
  logic [KW-1:0]     out_key_r;
  logic              out_end_r;
  logic              out_ovf_r;
  logic              out_fire;

  function automatic logic precedes(logic desc, logic [KW-1:0] a, logic [KW-1:0] b);
    return desc ? (a > b) : (a < b);
  endfunction

  // store port
  always_comb begin
    if (cmd.shift) begin
      rd_addr = y_r - ADDR_W'(2);
    end else if (cmd.emit_rd) begin
      rd_addr = idx_r;
    end else begin
      rd_addr = y_r - ADDR_W'(1);
    end
  end

  assign wr_en   = cmd.shift | cmd.put;
  assign wr_data = cmd.shift ? rd_data_r : key_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[y_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // item and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r    <= 1'b0;
      count_r   <= '0;
      dropped_r <= 1'b0;
      idx_r     <= '0;
      final_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        desc_r <= cfg_descending;
      end
      if (cmd.load) begin
        final_r <= in_final_item;
      end
      if (cmd.drop) begin
        dropped_r <= 1'b1;
      end
      if (cmd.put) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.advance) begin
        idx_r <= idx_r + ADDR_W'(1);
      end
      if (cmd.clear) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
        idx_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key[KW-1:0];
      y_r   <= count_r[ADDR_W-1:0];
    end else if (cmd.shift) begin
      y_r <= y_r - ADDR_W'(1);
    end
  end

  // output word register
  assign out_fire = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_key_r <= rd_data_r;
      out_end_r <= (CNT_W'(idx_r) == count_r - CNT_W'(1));
      out_ovf_r <= dropped_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = isort_pkg::FIELD_W'(out_key_r);
  assign out_run_end    = out_end_r;
  assign out_overflow   = out_ovf_r;

  always_comb begin
    stat            = '0;
    stat.full       = (count_r == CNT_W'(isort_pkg::DEPTH));
    stat.empty      = (count_r == '0);
    stat.precede    = precedes(desc_r, key_r, rd_data_r);
    stat.y_one      = (y_r == ADDR_W'(1));
    stat.final_item = final_r;
    stat.out_fire   = out_fire;
    stat.run_end    = out_end_r;
  end

  `ISORT_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(isort_pkg::DEPTH))
  `ISORT_ASSERT_IMP(a_shift_y, clk, rst_n, cmd.shift, y_r != '0)
  `ISORT_ASSERT_IMP(a_put_room, clk, rst_n, cmd.put, count_r < CNT_W'(isort_pkg::DEPTH))
  `ISORT_ASSERT_NXT(a_put_count, clk, rst_n, cmd.put, count_r == $past(count_r) + CNT_W'(1))

endmodule

// File: rtl/core/insertion_sorter.sv
// Insertion sorter: keys arrive one word at a time and are placed into a sorted store of
// DEPTH entries; a word with final_item set closes the set and the whole run is sent out
// in order (ascending, or descending when cfg descending is 1), with run_end on its last
// word and overflow on every word if keys beyond DEPTH were dropped. Equal keys keep their
// arrival order. The store is a RAM with one write port and one registered read port, and
// each insertion walks it from the top, moving one entry per cycle, and then writes the key
// into the gap; a key that arrives while the store is full is dropped. Emission reads each
// key, loads it into the output word and holds it until it is taken. No input is taken
// while a run is sent. The store needs no clearing after reset.
module insertion_sorter (
  input  logic         clk,
  input  logic         rst_n,
  isort_in_if.sink     in_ch,
  isort_out_if.source  out_ch,
  isort_cfg_if.sink    cfg_ch
);

  isort_pkg::isort_cmd_t  cmd;
  isort_pkg::isort_stat_t stat;
  logic                   cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  isort_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_final_item (in_ch.final_item),
    .in_ready      (in_ch.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  isort_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_key         (in_ch.key),
    .in_final_item  (in_ch.final_item),
    .cfg_valid      (cfg_fire),
    .cfg_descending (cfg_ch.descending),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_sorted_key (out_ch.sorted_key),
    .out_run_end    (out_ch.run_end),
    .out_overflow   (out_ch.overflow),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// File: verif/insertion_sorter_check.sv
`timescale 1ns / 1ps

module insertion_sorter_check
  import isort_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  isort_in_if   in_ch,
  isort_out_if  out_ch,
  isort_cfg_if  cfg_ch,
  output int    errors,
  output int    pending
);

  localparam logic [63:0] KEY_MASK64 =
    (KEY_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << KEY_WIDTH) - 64'd1);

  typedef struct packed {
    logic [FIELD_W-1:0] sorted_key;
    logic               run_end;
    logic               overflow;
  } sorted_word_t;

  logic [FIELD_W-1:0] key_store [DEPTH];
  int                 stored;
  logic               dropped;
  logic               desc_order;
  sorted_word_t       sorted_words [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    $display("insertion_sorter_check: %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic goes_before(input logic [FIELD_W-1:0] a,
                                       input logic [FIELD_W-1:0] b);
    return desc_order ? (a > b) : (a < b);
  endfunction

  task automatic take_key(input logic [FIELD_W-1:0] key_in, input logic last);
    logic [FIELD_W-1:0] k;
    int                 pos;
    sorted_word_t       w;
    k = key_in & KEY_MASK64[FIELD_W-1:0];
    if (stored >= DEPTH) begin
      dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < stored && !goes_before(k, key_store[pos])) pos++;
      for (int y = stored; y > pos; y--) key_store[y] = key_store[y-1];
      key_store[pos] = k;
      stored++;
    end
    if (last) begin
      for (int i = 0; i < stored; i++) begin
        w.sorted_key = key_store[i];
        w.run_end    = (i == stored - 1);
        w.overflow   = dropped;
        sorted_words.push_back(w);
      end
      stored  = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic check_word(input logic [FIELD_W-1:0] got_key, input logic got_end,
                            input logic got_ovf);
    sorted_word_t w;
    if (sorted_words.size() == 0) begin
      report($sformatf("unexpected word key %h run_end %b overflow %b",
                       got_key, got_end, got_ovf));
    end else begin
      w = sorted_words.pop_front();
      if (got_key !== w.sorted_key)
        report($sformatf("sorted_key %h, wanted %h", got_key, w.sorted_key));
      if (got_end !== w.run_end)
        report($sformatf("run_end %b, wanted %b (key %h)", got_end, w.run_end, w.sorted_key));
      if (got_ovf !== w.overflow)
        report($sformatf("overflow %b, wanted %b (key %h)", got_ovf, w.overflow, w.sorted_key));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stored     = 0;
      dropped    = 1'b0;
      desc_order = 1'b0;
      sorted_words.delete();
    end else begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) desc_order = cfg_ch.descending;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) take_key(in_ch.key, in_ch.final_item);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_word(out_ch.sorted_key, out_ch.run_end, out_ch.overflow);
    end
    pending = sorted_words.size();
  end

endmodule

// File: verif/insertion_sorter_test.sv
`timescale 1ns / 1ps

module insertion_sorter_test;
  import isort_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 100;
  localparam int PHASE_KEYS  = 70;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  isort_in_if  in_ch ();
  isort_out_if out_ch ();
  isort_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  int quiet = 0;
  int sent_keys = 0;
  int sets_sent = 0;
  int words_out = 0;

  insertion_sorter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  insertion_sorter_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (fail_count),
    .pending (pending)
  );

  always #10 clk = ~clk;

  // receiver, with one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) words_out <= words_out + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("insertion_sorter_test: no word moved for %0d cycles", QUIET_LIMIT);
      $display("insertion_sorter_test: done, errors");
      $finish;
    end
  end

  task automatic send_word(input logic [FIELD_W-1:0] k, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key        <= k;
    in_ch.final_item <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sent_keys++;
    if (last) sets_sent++;
  endtask

  function automatic logic [FIELD_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(3);
    case (sel)
      0: return FIELD_W'($urandom_range(7));
      1: return {FIELD_W{1'b1}} - FIELD_W'($urandom_range(7));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_word(pick_key(), i == n - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_order(input logic desc);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.descending <= desc;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic desc, input int s_idle, input int r_idle);
    int start;
    int pick;
    set_order(desc);
    send_idle = s_idle;
    recv_idle = r_idle;
    start = sent_keys;
    while (sent_keys - start < PHASE_KEYS) begin
      pick = $urandom_range(99);
      if (pick < 70) send_set($urandom_range(1, 6));
      else if (pick < 85) send_set($urandom_range(7, DEPTH - 1));
      else send_set($urandom_range(DEPTH, DEPTH + 4));
    end
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.key         <= '0;
    in_ch.final_item  <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.descending <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascending extremes, duplicates, single-key set
    set_order(1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0007, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);

    // descending extremes and equal keys
    set_order(1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b1);
    send_word(32'h0000_0000, 1'b1);

    run_phase(1'b0, 0, 0);
    run_phase(1'b1, 84, 0);
    run_phase(1'b0, 0, 84);
    run_phase(1'($urandom_range(1)), 27, 27);

    // long output hold while the sender keeps pushing
    set_order(1'b1);
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    for (int s = 0; s < 4; s++) send_set(6);

    drain();
    $display("insertion_sorter_test: %0d keys in %0d sets, %0d sorted words checked",
             sent_keys, sets_sent, words_out);
    $display("insertion_sorter_test: both orders, full and overflowing sets, idle mixes, hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("insertion_sorter_test: done, clean");
    end else begin
      $display("insertion_sorter_test: done, errors");
    end
    $finish;
  end

endmodule
